/* sv/igf_pkg.sv */
// Shared types and constants of the idle-gap half-duplex framer.
package igf_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam logic [15:0] IDLE_TICKS_RESET = 16'd256;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_TX_DONE = 2'd1,
      OP_TICK    = 2'd2,
      OP_SEND    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RX_SWEEP,
      ST_TX_READ,
      ST_TX_OUT
   } state_type;

   typedef enum logic [1:0] {
      LOAD_IDLE = 2'd0,
      LOAD_FILL = 2'd1,
      LOAD_DROP = 2'd2
   } load_type;

   localparam logic KIND_RX_FRAME = 1'b0;
   localparam logic KIND_TX_LINE  = 1'b1;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       start;
      logic       take;
   } rx_cmd_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       last;
      logic       busy;
   } rx_stat_type;

   typedef struct packed {
      logic       clear_len;
      logic       write;
      logic [7:0] data;
      logic       rewind;
      logic       read;
   } tx_cmd_type;

   typedef struct packed {
      logic       more;
      logic [7:0] rdata;
   } tx_stat_type;

endpackage

/* sv/igf_rx_store.sv */
// Receive frame store with its fill count and the read-ahead delivery sweep.
module igf_rx_store import igf_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  rx_cmd_type  cmd,
   output rx_stat_type stat
);

   localparam int IW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int CW = $clog2(FRAME_BYTES + 1);

   logic [7:0]    rx_mem [FRAME_BYTES];
   logic [7:0]    rdata_ff;
   logic          last_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          sweep_ff, sweep_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          dv_ff, dv_in;
   logic          mem_wr;
   logic          rd_en;
   logic          last_rd;

   always_comb begin
      mem_wr  = cmd.push && (count_ff < CW'(FRAME_BYTES));
      // A new read is issued when the read register is empty or drains now.
      rd_en   = sweep_ff && (!dv_ff || cmd.take);
      last_rd = ((rd_idx_ff + CW'(1)) == count_ff);

      count_in  = count_ff;
      ovf_in    = ovf_ff;
      sweep_in  = sweep_ff;
      rd_idx_in = rd_idx_ff;

      if (cmd.push) begin
         if (mem_wr) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.start) begin
         rd_idx_in = '0;
         // An overflowed or empty frame is discarded without delivery.
         if (ovf_ff || (count_ff == '0)) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sweep_in = 1'b1;
         end
      end
      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CW'(1);
         if (last_rd) begin
            sweep_in = 1'b0;
            count_in = '0;
         end
      end
      dv_in = rd_en || (dv_ff && !cmd.take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         sweep_ff  <= 1'b0;
         rd_idx_ff <= '0;
         dv_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         sweep_ff  <= sweep_in;
         rd_idx_ff <= rd_idx_in;
         dv_ff     <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         rx_mem[count_ff[IW-1:0]] <= cmd.data;
      end
      if (rd_en) begin
         rdata_ff <= rx_mem[rd_idx_ff[IW-1:0]];
         last_ff  <= last_rd;
      end
   end

   assign stat.byte_valid = dv_ff;
   assign stat.byte_value = rdata_ff;
   assign stat.last       = last_ff;
   assign stat.busy       = sweep_ff || dv_ff;

endmodule

/* sv/igf_tx_store.sv */
// Transmit message store with its length and send index.
module igf_tx_store import igf_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  tx_cmd_type  cmd,
   output tx_stat_type stat
);

   localparam int IW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int CW = $clog2(FRAME_BYTES + 1);

   logic [7:0]    tx_mem [FRAME_BYTES];
   logic [7:0]    rdata_ff;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] len_eff;
   logic          mem_wr;

   always_comb begin
      // The first byte of a message restarts the store in the same cycle.
      len_eff = cmd.clear_len ? '0 : len_ff;
      mem_wr  = cmd.write && (len_eff < CW'(FRAME_BYTES));
      len_in  = mem_wr ? (len_eff + CW'(1)) : len_eff;
      idx_in  = idx_ff;
      if (cmd.rewind) begin
         idx_in = '0;
      end else if (cmd.read) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         idx_ff <= '0;
      end else begin
         len_ff <= len_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         tx_mem[len_eff[IW-1:0]] <= cmd.data;
      end
      if (cmd.read) begin
         rdata_ff <= tx_mem[idx_ff[IW-1:0]];
      end
   end

   assign stat.more  = (idx_ff < len_ff);
   assign stat.rdata = rdata_ff;

endmodule

/* sv/idle_gap_half_duplex_framer.sv */
// Top level of the idle-gap half-duplex framer: event decode, bus state and result register.
//
//   channel | ports   | beat contents
//   --------+---------+-----------------------------------------------------------
//   event   | req_*   | tuser opcode, tdata line or message byte, tlast end of message
//   result  | rsp_*   | tuser kind, tdata byte value, tlast frame end
//   config  | csr_*   | idle_ticks, written whenever csr_wr_en is high
//
// An event beat is taken whenever the block is idle. A frame end delivers the stored frame
// at one byte per cycle while rsp is ready, from the receive store's read port.
// A transmit byte passes through accept, store read and result register load, in that order.
// Reset is synchronous; the stores keep their contents and are never read before written.
// A stall on rsp holds the result register and pauses delivery; no beat is lost.
module idle_gap_half_duplex_framer import igf_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] byte_value
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   state_type   state_ff, state_in;
   load_type    load_ff, load_in;
   logic [15:0] idle_ticks_ff;
   logic [15:0] idle_count_ff, idle_count_in;
   logic        idle_run_ff, idle_run_in;
   logic        bus_free_ff, bus_free_in;
   logic        tx_wait_ff, tx_wait_in;
   logic        tx_active_ff, tx_active_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_kind_ff, out_kind_in;
   logic        out_end_ff, out_end_in;

   rx_cmd_type  rx_cmd;
   rx_stat_type rx_stat;
   tx_cmd_type  tx_cmd;
   tx_stat_type tx_stat;

   logic        accept;
   logic        can_load;
   op_type      op;
   logic [15:0] idle_next;
   load_type    phase;

   igf_rx_store #(.FRAME_BYTES(FRAME_BYTES)) u_rx_store (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .stat  (rx_stat)
   );

   igf_tx_store #(.FRAME_BYTES(FRAME_BYTES)) u_tx_store (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .stat  (tx_stat)
   );

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      op         = op_type'(req_tuser);
      can_load   = !out_valid_ff || rsp_tready;
      idle_next  = (idle_count_ff == 16'hFFFF) ? idle_count_ff : (idle_count_ff + 16'd1);
      phase      = load_ff;

      state_in      = state_ff;
      load_in       = load_ff;
      idle_count_in = idle_count_ff;
      idle_run_in   = idle_run_ff;
      bus_free_in   = bus_free_ff;
      tx_wait_in    = tx_wait_ff;
      tx_active_in  = tx_active_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_end_in   = out_end_ff;

      rx_cmd = '{push: 1'b0, data: req_tdata, start: 1'b0, take: 1'b0};
      tx_cmd = '{clear_len: 1'b0, write: 1'b0, data: req_tdata, rewind: 1'b0, read: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_RX_BYTE: begin
                     bus_free_in   = 1'b0;
                     rx_cmd.push   = 1'b1;
                     idle_count_in = '0;
                     idle_run_in   = 1'b1;
                  end
                  OP_TX_DONE: begin
                     if (tx_active_ff) begin
                        if (tx_stat.more) begin
                           state_in = ST_TX_READ;
                        end else begin
                           tx_active_in = 1'b0;
                           bus_free_in  = 1'b1;
                        end
                     end
                  end
                  OP_TICK: begin
                     if (idle_run_ff) begin
                        if (idle_next >= idle_ticks_ff) begin
                           idle_run_in   = 1'b0;
                           idle_count_in = '0;
                           rx_cmd.start  = 1'b1;
                           state_in      = ST_RX_SWEEP;
                        end else begin
                           idle_count_in = idle_next;
                        end
                     end
                  end
                  OP_SEND: begin
                     if (load_ff != LOAD_FILL && load_ff != LOAD_DROP) begin
                        if (tx_active_ff || tx_wait_ff) begin
                           phase = LOAD_DROP;
                        end else begin
                           phase            = LOAD_FILL;
                           tx_cmd.clear_len = 1'b1;
                        end
                     end
                     tx_cmd.write = (phase == LOAD_FILL);
                     load_in      = phase;
                     if (req_tlast) begin
                        if (phase == LOAD_FILL) begin
                           tx_cmd.rewind = 1'b1;
                           if (bus_free_ff) begin
                              bus_free_in  = 1'b0;
                              tx_active_in = 1'b1;
                              state_in     = ST_TX_READ;
                           end else begin
                              tx_wait_in = 1'b1;
                           end
                        end
                        load_in = LOAD_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RX_SWEEP: begin
            if (rx_stat.byte_valid && can_load) begin
               rx_cmd.take  = 1'b1;
               out_valid_in = 1'b1;
               out_byte_in  = rx_stat.byte_value;
               out_kind_in  = KIND_RX_FRAME;
               out_end_in   = rx_stat.last;
            end
            if (!rx_stat.busy) begin
               if (tx_wait_ff) begin
                  tx_active_in = 1'b1;
                  tx_wait_in   = 1'b0;
                  state_in     = ST_TX_READ;
               end else begin
                  bus_free_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_TX_READ: begin
            tx_cmd.read = 1'b1;
            state_in    = ST_TX_OUT;
         end
         ST_TX_OUT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_byte_in  = tx_stat.rdata;
               out_kind_in  = KIND_TX_LINE;
               out_end_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_ff       <= LOAD_IDLE;
         idle_ticks_ff <= IDLE_TICKS_RESET;
         idle_count_ff <= '0;
         idle_run_ff   <= 1'b0;
         bus_free_ff   <= 1'b1;
         tx_wait_ff    <= 1'b0;
         tx_active_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_ff       <= load_in;
         idle_count_ff <= idle_count_in;
         idle_run_ff   <= idle_run_in;
         bus_free_ff   <= bus_free_in;
         tx_wait_ff    <= tx_wait_in;
         tx_active_ff  <= tx_active_in;
         out_valid_ff  <= out_valid_in;
         if (csr_wr_en) begin
            idle_ticks_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

/* tb/igf_result_checker.sv */
`timescale 1ns / 1ps
// Watches both channels of the framer, predicts every result beat and compares it.
module igf_result_checker import igf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          beats_due
);

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       frame_end;
   } line_beat_type;

   line_beat_type due_beats[$];

   // Mirror of the framer's state.
   logic [7:0]  rx_bytes [FRAME_BYTES_DEF];
   int          rx_fill;
   bit          rx_overrun;
   logic [15:0] silence;
   bit          silence_armed;
   logic [7:0]  tx_bytes [FRAME_BYTES_DEF];
   int          tx_next;
   int          tx_len;
   bit          bus_free;
   bit          tx_deferred;
   bit          tx_busy;
   load_type    loader;
   logic [15:0] idle_limit;

   task automatic clear_state();
      rx_fill       = 0;
      rx_overrun    = 0;
      silence       = '0;
      silence_armed = 0;
      tx_next       = 0;
      tx_len        = 0;
      bus_free      = 1;
      tx_deferred   = 0;
      tx_busy       = 0;
      loader        = LOAD_IDLE;
      idle_limit    = IDLE_TICKS_RESET;
      due_beats.delete();
   endtask

   task automatic emit_tx_byte();
      logic [7:0] b;
      b = 8'h00;
      if (tx_next < tx_len && tx_next < FRAME_BYTES_DEF) b = tx_bytes[tx_next];
      tx_next++;
      due_beats.push_back('{kind: KIND_TX_LINE, value: b, frame_end: 1'b1});
   endtask

   task automatic apply_event(op_type op, logic [7:0] d, logic eom);
      case (op)
         OP_RX_BYTE: begin
            bus_free = 0;
            if (rx_fill < FRAME_BYTES_DEF) begin
               rx_bytes[rx_fill] = d;
               rx_fill++;
            end else begin
               rx_overrun = 1;
            end
            silence       = '0;
            silence_armed = 1;
         end
         OP_TX_DONE: begin
            if (tx_busy) begin
               if (tx_next < tx_len) begin
                  emit_tx_byte();
               end else begin
                  tx_busy  = 0;
                  bus_free = 1;
               end
            end
         end
         OP_TICK: begin
            if (silence_armed) begin
               if (silence != 16'hFFFF) silence++;
               if (silence >= idle_limit) begin
                  silence_armed = 0;
                  silence       = '0;
                  // An overrun frame is thrown away, but the bus still moves on.
                  if (!rx_overrun) begin
                     for (int i = 0; i < rx_fill; i++)
                        due_beats.push_back('{kind: KIND_RX_FRAME, value: rx_bytes[i],
                                              frame_end: (i + 1 == rx_fill)});
                  end
                  rx_fill    = 0;
                  rx_overrun = 0;
                  if (tx_deferred) begin
                     tx_busy     = 1;
                     tx_deferred = 0;
                     emit_tx_byte();
                  end else begin
                     bus_free = 1;
                  end
               end
            end
         end
         default: begin
            if (loader == LOAD_IDLE) begin
               if (tx_busy || tx_deferred) begin
                  loader = LOAD_DROP;
               end else begin
                  loader = LOAD_FILL;
                  tx_len = 0;
               end
            end
            if (loader == LOAD_FILL && tx_len < FRAME_BYTES_DEF) begin
               tx_bytes[tx_len] = d;
               tx_len++;
            end
            if (eom) begin
               if (loader == LOAD_FILL) begin
                  tx_next = 0;
                  if (bus_free) begin
                     bus_free = 0;
                     tx_busy  = 1;
                     emit_tx_byte();
                  end else begin
                     tx_deferred = 1;
                  end
               end
               loader = LOAD_IDLE;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      line_beat_type want;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               $error("unexpected result beat: kind %0d byte_value %02h frame_end %0d",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = due_beats.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata !== want.value) begin
                  $error("byte_value: expected %02h, actual %02h", want.value, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d", want.frame_end, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) apply_event(op_type'(req_tuser), req_tdata, req_tlast);
         if (csr_wr_en) idle_limit = csr_wr_data;
      end
      beats_due = due_beats.size();
   end

endmodule

/* tb/idle_gap_half_duplex_framer_tb.sv */
`timescale 1ns / 1ps
// Top of the framer testbench: clock, reset, event and config stimulus, and the verdict.
module idle_gap_half_duplex_framer_tb;
   import igf_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   int mismatch_count;
   int beats_due;
   int events_sent;
   int steady_left;
   bit hold_req;

   idle_gap_half_duplex_framer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   igf_result_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .beats_due      (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: random stalls, stretches of steady readiness, and one long hold-off.
   initial begin
      int stall_left;
      int free_left;
      int r;
      bit hold_taken;
      stall_left = 0;
      free_left  = 0;
      hold_taken = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1;
            stall_left = HOLD_CYCLES;
            free_left  = 0;
         end
         if (stall_left == 0 && free_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60)      free_left  = $urandom_range(1, 8);
            else if (r < 88) stall_left = $urandom_range(1, 3);
            else if (r < 96) stall_left = $urandom_range(4, 12);
            else if (r < 98) stall_left = $urandom_range(20, 50);
            else             free_left  = $urandom_range(100, 300);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            free_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   // Ends the run when no beat moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // with tvalid still high so that a following beat needs no second assignment.
   task automatic push_event(op_type op, logic [7:0] d, logic eom);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic push_ticks(int n);
      for (int i = 0; i < n; i++) push_event(OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic push_tx_done(int n);
      for (int i = 0; i < n; i++) push_event(OP_TX_DONE, 8'($urandom), 1'($urandom));
   endtask

   // Line bytes of one frame, now and then interleaved with a transmit completion.
   task automatic rx_frame_seq(int len);
      for (int i = 0; i < len; i++) begin
         push_event(OP_RX_BYTE, 8'($urandom), 1'($urandom));
         if ($urandom_range(0, 5) == 0) push_event(OP_TX_DONE, 8'($urandom), 1'b0);
      end
   endtask

   task automatic message_seq(int len);
      for (int i = 0; i < len; i++) push_event(OP_SEND, 8'($urandom), i == len - 1);
   endtask

   // Waits until every predicted beat has arrived and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (beats_due != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_idle_limit(logic [15:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(int target, int lim);
      int start;
      int r;
      start = events_sent;
      while (events_sent - start < target) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            if ($urandom_range(0, 11) == 0) rx_frame_seq($urandom_range(30, 36));
            else rx_frame_seq($urandom_range(1, 6));
            // Mostly enough silence to end the frame, sometimes a little short.
            if ($urandom_range(0, 3) != 0) push_ticks(lim);
            else push_ticks($urandom_range(0, lim - 1));
         end else if (r < 55) begin
            if ($urandom_range(0, 9) == 0) message_seq($urandom_range(30, 36));
            else message_seq($urandom_range(1, 5));
         end else if (r < 75) begin
            push_tx_done($urandom_range(1, 4));
         end else if (r < 85) begin
            push_ticks($urandom_range(1, lim));
         end else begin
            push_event(op_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = OP_RX_BYTE;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 16'h0000;
      events_sent = 0;
      steady_left = 0;
      hold_req    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first at the reset idle limit.
      push_event(OP_SEND, 8'h00, 1'b0);
      push_event(OP_SEND, 8'hFF, 1'b1);       // free bus: first byte goes out at once
      push_tx_done(2);
      push_event(OP_TX_DONE, 8'hFF, 1'b1);    // nothing active, ignored
      push_event(OP_RX_BYTE, 8'hFF, 1'b1);
      push_event(OP_RX_BYTE, 8'h00, 1'b0);
      push_event(OP_SEND, 8'h81, 1'b1);       // bus busy, so this one waits
      push_event(OP_SEND, 8'h42, 1'b0);       // dropped whole while one is waiting
      push_event(OP_SEND, 8'h24, 1'b1);
      // A short idle limit ends the pending frame after two ticks.
      write_idle_limit(16'd2);
      push_ticks(2);
      push_event(OP_RX_BYTE, 8'h3C, 1'b0);    // received while transmitting
      push_event(OP_TX_DONE, 8'h00, 1'b0);

      write_idle_limit(16'd1);
      push_event(OP_TICK, 8'hFF, 1'b1);
      push_event(OP_TICK, 8'h00, 1'b0);       // no frame pending, ignored
      rx_frame_seq(FRAME_BYTES_DEF);
      push_event(OP_SEND, 8'h5A, 1'b1);
      push_event(OP_TICK, 8'h00, 1'b0);       // full frame plus the waiting byte
      push_tx_done(2);

      // Overrun frame and an over-long message, then random traffic.
      rx_frame_seq(FRAME_BYTES_DEF + 2);
      push_ticks(1);
      message_seq(FRAME_BYTES_DEF + 3);
      push_tx_done(FRAME_BYTES_DEF + 1);
      random_phase(40, 1);

      write_idle_limit(16'd4);
      random_phase(40, 4);

      // Hold the result side off while beats keep coming, so the block backs up.
      write_idle_limit(16'd2);
      hold_req    = 1;
      steady_left = 1000;
      push_tx_done(4);
      message_seq(12);
      push_tx_done(6);
      rx_frame_seq(8);
      push_ticks(2);
      steady_left = 0;
      random_phase(40, 2);

      write_idle_limit(16'd7);
      random_phase(40, 7);

      // At the longest idle limit a few ticks leave the frame pending.
      write_idle_limit(16'hFFFF);
      push_tx_done(2);
      push_event(OP_RX_BYTE, 8'h96, 1'b0);
      push_event(OP_RX_BYTE, 8'h69, 1'b0);
      message_seq(1);
      push_ticks(3);
      push_tx_done(2);

      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* idle_gap_half_duplex_framer.f */
sv/igf_pkg.sv
sv/igf_rx_store.sv
sv/igf_tx_store.sv
sv/idle_gap_half_duplex_framer.sv
tb/igf_result_checker.sv
tb/idle_gap_half_duplex_framer_tb.sv
